@@ src/qte_pkg.sv @@
// Package: shared constants, types and tables for the quaternion to Euler angle core.
package qte_pkg;

  localparam int unsigned CordicStepsDef   = 16;
  localparam int unsigned AngleFracBitsDef = 13;

  // Width of a CORDIC x/y word: Q.28 sums reach about 2^33 for odd inputs
  localparam int unsigned DataW = 40;
  localparam int unsigned AngW  = 34;

  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cvec_t;

  typedef struct packed {
    cvec_t roll;
    cvec_t pitch;
    cvec_t yaw;
    logic  clamp;
    logic  clamp_neg;
  } lane_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned i);
    logic signed [AngW-1:0] r;
    unique case (i)
      0: r = 34'sd843314857;  1: r = 34'sd497837829;  2: r = 34'sd263043837;
      3: r = 34'sd133525159;  4: r = 34'sd67021687;   5: r = 34'sd33543516;
      6: r = 34'sd16775851;   7: r = 34'sd8388437;    8: r = 34'sd4194283;
      9: r = 34'sd2097149;    10: r = 34'sd1048576;   11: r = 34'sd524288;
      12: r = 34'sd262144;    13: r = 34'sd131072;    14: r = 34'sd65536;
      15: r = 34'sd32768;     16: r = 34'sd16384;     17: r = 34'sd8192;
      18: r = 34'sd4096;      19: r = 34'sd2048;      20: r = 34'sd1024;
      21: r = 34'sd512;       22: r = 34'sd256;       23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Start a vectoring run: fold the left half plane
  function automatic cvec_t cv_init(input logic signed [DataW-1:0] s,
                                    input logic signed [DataW-1:0] c);
    cvec_t v;
    v.x = c;
    v.y = s;
    v.z = '0;
    if (c < 0) begin
      v.z = (s >= 0) ? PiQ30 : -PiQ30;
      v.x = -c;
      v.y = -s;
    end
    return v;
  endfunction

  function automatic cvec_t cv_step(input cvec_t v, input int unsigned i);
    cvec_t r;
    logic signed [DataW-1:0] dx, dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    r = v;
    if (v.y >= 0) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_q30(i);
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_q30(i);
    end
    return r;
  endfunction

endpackage

@@ src/qte_sqrt_cell.sv @@
// Sqrt cell: one restoring digit of the floor square root per stage.
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int unsigned BitPos = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [56:0] rem_i,
  input  logic [56:0] root_i,
  output logic [56:0] rem_o,
  output logic [56:0] root_o
);
  logic [56:0] bit_w, trial_w, rem_d, root_d;
  logic [56:0] rem_q, root_q;

  always_comb begin
    bit_w   = 57'd1 << (2 * BitPos);
    trial_w = root_i + bit_w;
    if (rem_i >= trial_w) begin
      rem_d  = rem_i - trial_w;
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

@@ src/qte_cordic_cell.sv @@
// CORDIC cell: one vectoring micro-rotation on all three lanes.
module qte_cordic_cell import qte_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  lane_t lane_i,
  output lane_t lane_o
);
  lane_t lane_d, lane_q;

  always_comb begin
    lane_d       = lane_i;
    lane_d.roll  = cv_step(lane_i.roll, Step);
    lane_d.pitch = cv_step(lane_i.pitch, Step);
    lane_d.yaw   = cv_step(lane_i.yaw, Step);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;
endmodule

@@ src/quaternion_to_euler_angles_core.sv @@
// Top level: pipelined quaternion to ZYX Euler angle converter.
//
//  channel | signals                                        | direction
//  in      | in_valid_i, in_stall_o, quat_{x,y,z,w}_i       | to core
//  out     | out_valid_o, out_stall_i, roll/pitch/yaw_angle_o, pitch_clamped_o | from core
//
// One beat per cycle while the output is not stalled; a beat passes the input register,
// the product stage, the square root row, the CORDIC row and the rounding stage.
// Reset clears the valid bits of every stage; payload is not reset.
// The whole pipe holds while the output beat is stalled; in_stall_o follows it.
module quaternion_to_euler_angles_core import qte_pkg::*; #(
  parameter int unsigned CORDIC_STEPS    = CordicStepsDef,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);
  localparam int unsigned SqN   = 29;
  localparam int unsigned Depth = 2 + SqN + CORDIC_STEPS;
  localparam int unsigned Sh    = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [AngW:0] PitchPos =
    ((AngW+1)'(HalfPiQ30) + ((AngW+1)'(1) <<< (Sh - 1))) >>> Sh;
  localparam logic signed [AngW:0] PitchNeg =
    ((AngW+1)'(-HalfPiQ30) + ((AngW+1)'(1) <<< (Sh - 1))) >>> Sh;

  logic [Depth-1:0] vld_q;
  logic             en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Stage 0: register inputs
  logic signed [15:0] x_q, y_q, z_q, w_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= quat_x_i; y_q <= quat_y_i; z_q <= quat_z_i; w_q <= quat_w_i;
    end
  end

  // Stage 1: products and sums in Q.28
  logic signed [DataW-1:0] sr_q, cr_q, sp_q, sy_q, cy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= DataW'(2 * (DataW'(w_q) * x_q + DataW'(y_q) * z_q));
      cr_q <= DataW'((DataW'(1) <<< 28) - 2 * (DataW'(x_q) * x_q + DataW'(y_q) * y_q));
      sp_q <= DataW'(2 * (DataW'(w_q) * y_q - DataW'(z_q) * x_q));
      sy_q <= DataW'(2 * (DataW'(w_q) * z_q + DataW'(x_q) * y_q));
      cy_q <= DataW'((DataW'(1) <<< 28) - 2 * (DataW'(y_q) * y_q + DataW'(z_q) * z_q));
    end
  end

  // Square root of 2^56 - sp^2, one digit per cell, side data delayed alongside
  logic signed [DataW-1:0] one_q28;
  logic                    cl_w, cn_w;
  logic [56:0]             rad_w;
  logic signed [DataW-1:0] spc_w;
  logic signed [28:0]      spn_w;
  logic signed [57:0]      sq_w;
  assign one_q28 = DataW'(1) <<< 28;
  assign cl_w    = (sp_q >= one_q28) || (sp_q <= -one_q28);
  assign cn_w    = sp_q < 0;
  assign spc_w   = cl_w ? '0 : sp_q;
  assign spn_w   = spc_w[28:0];
  assign sq_w    = spn_w * spn_w;
  assign rad_w   = (57'd1 << 56) - sq_w[56:0];

  logic [56:0] rem_c  [SqN+1];
  logic [56:0] root_c [SqN+1];
  logic signed [DataW-1:0] sr_d [SqN+1], cr_d [SqN+1], sp_d [SqN+1];
  logic signed [DataW-1:0] sy_d [SqN+1], cy_d [SqN+1];
  logic cl_d [SqN+1], cn_d [SqN+1];

  assign rem_c[0]  = rad_w;
  assign root_c[0] = '0;
  assign sr_d[0] = sr_q; assign cr_d[0] = cr_q; assign sp_d[0] = spc_w;
  assign sy_d[0] = sy_q; assign cy_d[0] = cy_q;
  assign cl_d[0] = cl_w; assign cn_d[0] = cn_w;

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    qte_sqrt_cell #(.BitPos(SqN - 1 - g)) u_cell (
      .clk_i, .en_i(en),
      .rem_i(rem_c[g]), .root_i(root_c[g]),
      .rem_o(rem_c[g+1]), .root_o(root_c[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_d[g+1] <= sr_d[g]; cr_d[g+1] <= cr_d[g]; sp_d[g+1] <= sp_d[g];
        sy_d[g+1] <= sy_d[g]; cy_d[g+1] <= cy_d[g];
        cl_d[g+1] <= cl_d[g]; cn_d[g+1] <= cn_d[g];
      end
    end
  end

  // CORDIC row
  lane_t lane_c [CORDIC_STEPS+1];
  always_comb begin
    lane_c[0].roll      = cv_init(sr_d[SqN], cr_d[SqN]);
    lane_c[0].yaw       = cv_init(sy_d[SqN], cy_d[SqN]);
    lane_c[0].pitch     = cv_init(sp_d[SqN], DataW'(root_c[SqN]));
    lane_c[0].clamp     = cl_d[SqN];
    lane_c[0].clamp_neg = cn_d[SqN];
    if (sr_d[SqN] == 0 && cr_d[SqN] == 0) lane_c[0].roll.x = '0;
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cd
    qte_cordic_cell #(.Step(s)) u_cell (
      .clk_i, .en_i(en), .lane_i(lane_c[s]), .lane_o(lane_c[s+1])
    );
  end

  // Zero vector stays at zero angle through every step
  logic                  zr_w, zy_w;
  logic [CORDIC_STEPS-1:0] zr_q, zy_q;
  assign zr_w = (sr_d[SqN] == 0) && (cr_d[SqN] == 0);
  assign zy_w = (sy_d[SqN] == 0) && (cy_d[SqN] == 0);
  always_ff @(posedge clk_i) begin
    if (en) begin
      zr_q <= {zr_q[CORDIC_STEPS-2:0], zr_w};
      zy_q <= {zy_q[CORDIC_STEPS-2:0], zy_w};
    end
  end

  // Rounding stage
  lane_t                 fin;
  logic signed [AngW-1:0] zr, zp, zy;
  logic signed [AngW:0]   rr, rp, ry;
  assign fin = lane_c[CORDIC_STEPS];
  assign zr  = zr_q[CORDIC_STEPS-1] ? '0 : fin.roll.z;
  assign zy  = zy_q[CORDIC_STEPS-1] ? '0 : fin.yaw.z;
  assign zp  = fin.clamp ? (fin.clamp_neg ? -HalfPiQ30 : HalfPiQ30) : fin.pitch.z;
  assign rr  = ((AngW+1)'(zr) + ((AngW+1)'(1) <<< (Sh - 1))) >>> Sh;
  assign rp  = ((AngW+1)'(zp) + ((AngW+1)'(1) <<< (Sh - 1))) >>> Sh;
  assign ry  = ((AngW+1)'(zy) + ((AngW+1)'(1) <<< (Sh - 1))) >>> Sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_angle_o    <= rr[15:0];
      pitch_angle_o   <= rp[14:0];
      yaw_angle_o     <= ry[15:0];
      pitch_clamped_o <= fin.clamp;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("pipe advanced under output stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(roll_angle_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pitch_clamped_o |->
      (pitch_angle_o == PitchPos[14:0]) || (pitch_angle_o == PitchNeg[14:0]))
    else $error("clamped pitch not at a right angle");
endmodule
